// ===== rtl/segmented_ring_pointer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// segmented_ring_pointer_unit_defines
// Assertion macros used by the ring pointer unit controller.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_RING_POINTER_UNIT_DEFINES_SVH
`define SEGMENTED_RING_POINTER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define SRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srpu_pkg.sv =====
// ----------------------------------------------------------------------------
// srpu_pkg
// Shared constants and control types of the segmented ring pointer unit.
// ----------------------------------------------------------------------------
package srpu_pkg;

  localparam int MaxSegDefault  = 6;
  localparam int OffBitsDefault = 16;
  localparam int SegBits        = 3;
  localparam int CountBits      = 16;
  localparam int CfgIdxBits     = 3;
  localparam int CfgDataBits    = 16;
  localparam int SumBits        = 19;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_WRAPS = 2'd2;
  localparam logic [1:0] CMD_DIST  = 2'd3;

  localparam logic [CfgIdxBits-1:0] REG_SEG_COUNT = 3'd0;

  localparam logic [CfgDataBits-1:0] LEN_RESET = 16'd256;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the request and reset the walk
    logic step;     // walk one segment
    logic commit;   // write back the walked pointer
  } srpu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic refuse;    // request is refused
    logic done;      // walk has finished after this step
    logic emit_step; // this step gives a piece result
  } srpu_sts_t;

endpackage

// ===== rtl/srpu_datapath.sv =====
// ----------------------------------------------------------------------------
// srpu_datapath
// Configuration, pointers, the one-segment-per-cycle walker and the result
// register.
// ----------------------------------------------------------------------------
module srpu_datapath #(
  parameter int MAX_SEGMENTS = srpu_pkg::MaxSegDefault,
  parameter int OFFSET_BITS  = srpu_pkg::OffBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srpu_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [srpu_pkg::CfgDataBits-1:0]  cfg_data,
  input  logic [1:0]                        in_cmd,
  input  logic [srpu_pkg::CountBits-1:0]    in_count,
  input  logic [srpu_pkg::SegBits-1:0]      in_first_segment,
  input  logic [OFFSET_BITS-1:0]            in_first_offset,
  input  logic [srpu_pkg::SegBits-1:0]      in_second_segment,
  input  logic [OFFSET_BITS-1:0]            in_second_offset,
  input  srpu_pkg::srpu_cmd_t               ctl,
  output srpu_pkg::srpu_sts_t               sts,
  input  logic                              out_set,
  output logic [srpu_pkg::SegBits-1:0]      out_piece_segment,
  output logic [OFFSET_BITS-1:0]            out_piece_offset,
  output logic [srpu_pkg::CountBits-1:0]    out_piece_size,
  output logic [srpu_pkg::CountBits-1:0]    out_answer_value,
  output logic                              out_last_piece,
  output logic                              out_error_flag
);
  import srpu_pkg::*;

  localparam int SB = SegBits;
  localparam int LB = CfgDataBits;
  localparam logic [SB-1:0] MaxSegV = SB'(MAX_SEGMENTS);

  logic [SB-1:0] seg_count_r;
  logic [LB-1:0] len_r [MAX_SEGMENTS];
  logic [SB-1:0] rd_seg_r, wr_seg_r;
  logic [OFFSET_BITS-1:0] rd_off_r, wr_off_r;

  // derived configuration, registered
  logic [SB-1:0]      used;
  logic [SumBits-1:0] sum;
  logic               zero_len;
  logic [LB-1:0]      total_r;
  logic               bad_cfg_r;

  always_comb begin
    if (seg_count_r == '0) used = SB'(1);
    else if (seg_count_r > MaxSegV) used = MaxSegV;
    else used = seg_count_r;
    sum = '0;
    zero_len = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (SB'(i) < used) begin
        sum = sum + SumBits'(len_r[i]);
        if (len_r[i] == '0) zero_len = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= SB'(1);
      for (int i = 0; i < MAX_SEGMENTS; i++) len_r[i] <= LEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SEG_COUNT) seg_count_r <= cfg_data[SB-1:0];
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (cfg_index == CfgIdxBits'(i + 1)) len_r[i] <= cfg_data;
      end
    end
    total_r   <= sum[LB-1:0];
    bad_cfg_r <= zero_len | (|sum[SumBits-1:LB]);
  end

  // walk state
  logic [1:0]               cmd_r;
  logic [CountBits-1:0]     rem_r;
  logic [SB-1:0]            seg_r, sseg_r;
  logic [OFFSET_BITS-1:0]   off_r, soff_r;
  logic [3:0]               n_r;
  logic [LB-1:0]            dist_r;
  logic                     refuse_r;
  logic                     refuse_now;

  logic [SB-1:0]          src_seg;
  logic [OFFSET_BITS-1:0] src_off;
  logic                   ptr_ok, ptr2_ok, refuse_nxt;

  function automatic logic pok(input logic [SB-1:0] s, input logic [OFFSET_BITS-1:0] o,
                               input logic [SB-1:0] u, input logic [LB-1:0] l);
    pok = (s < u) && (LB'(o) < l);
  endfunction

  logic [LB-1:0] len_src, len_fst, len_snd;
  always_comb begin
    len_src = '0; len_fst = '0; len_snd = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (src_seg == SB'(i)) len_src = len_r[i];
      if (in_first_segment == SB'(i)) len_fst = len_r[i];
      if (in_second_segment == SB'(i)) len_snd = len_r[i];
    end
  end

  always_comb begin
    src_seg = (in_cmd == CMD_READ) ? rd_seg_r : wr_seg_r;
    src_off = (in_cmd == CMD_READ) ? rd_off_r : wr_off_r;
    ptr_ok  = pok(src_seg, src_off, used, len_src);
    ptr2_ok = pok(in_first_segment, in_first_offset, used, len_fst) &&
              pok(in_second_segment, in_second_offset, used, len_snd);
    if (in_cmd == CMD_DIST) refuse_nxt = !ptr2_ok;
    else refuse_nxt = !ptr_ok;
  end

  // check size and count in the walk, once the registered ring size is current
  assign refuse_now = refuse_r || bad_cfg_r || (cmd_r != CMD_DIST && rem_r > total_r);

  // one step of the walk
  logic [LB-1:0]   len_cur, space;
  logic [SB-1:0]   seg_next;
  logic            fits, walk_done;
  always_comb begin
    len_cur = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) if (seg_r == SB'(i)) len_cur = len_r[i];
    space    = len_cur - LB'(off_r);
    fits     = space > rem_r;
    seg_next = (seg_r + SB'(1) >= used) ? '0 : seg_r + SB'(1);
    if (cmd_r == CMD_DIST) walk_done = (seg_r == sseg_r);
    else walk_done = fits || (rem_r == space) || (n_r == 4'(MAX_SEGMENTS));
  end

  assign sts.refuse    = refuse_now;
  assign sts.done      = walk_done || (cmd_r != CMD_DIST && rem_r == '0);
  assign sts.emit_step = (cmd_r == CMD_READ) || (cmd_r == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_cmd;
      rem_r    <= in_count;
      refuse_r <= refuse_nxt;
      n_r      <= '0;
      sseg_r   <= in_second_segment;
      soff_r   <= in_second_offset;
      if (in_cmd == CMD_DIST) begin
        seg_r  <= in_first_segment;
        off_r  <= in_first_offset;
        dist_r <= '0;
      end else begin
        seg_r  <= src_seg;
        off_r  <= src_off;
        dist_r <= '0;
      end
    end else if (ctl.step) begin
      if (cmd_r == CMD_DIST) begin
        if (seg_r == sseg_r) begin
          if (n_r == '0) begin
            if (off_r <= soff_r) dist_r <= LB'(soff_r - off_r);
            else dist_r <= total_r - LB'(off_r - soff_r);
          end else begin
            dist_r <= dist_r + LB'(soff_r);
          end
        end else begin
          dist_r <= dist_r + space;
          seg_r  <= seg_next;
          off_r  <= '0;
        end
        n_r <= n_r + 4'd1;
      end else if (rem_r != '0) begin
        if (fits) begin
          off_r <= off_r + OFFSET_BITS'(rem_r);
          rem_r <= '0;
        end else begin
          rem_r <= rem_r - space;
          seg_r <= seg_next;
          off_r <= '0;
        end
        n_r <= n_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_seg_r <= '0; rd_off_r <= '0;
      wr_seg_r <= '0; wr_off_r <= '0;
    end else if (ctl.commit) begin
      if (cmd_r == CMD_READ) begin
        rd_seg_r <= seg_r; rd_off_r <= off_r;
      end else if (cmd_r == CMD_WRITE) begin
        wr_seg_r <= seg_r; wr_off_r <= off_r;
      end
    end
  end

  // result register; loaded on out_set and held until the next out_set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_last_piece <= 1'b0;
      out_error_flag <= 1'b0;
    end else if (out_set) begin
      out_piece_segment <= '0;
      out_piece_offset  <= '0;
      out_piece_size    <= '0;
      out_answer_value  <= '0;
      out_error_flag    <= refuse_now;
      out_last_piece    <= refuse_now || sts.done;
      if (!refuse_now) begin
        case (cmd_r)
          CMD_READ, CMD_WRITE: begin
            out_piece_segment <= seg_r;
            out_piece_offset  <= off_r;
            out_piece_size    <= (rem_r == '0) ? '0 : (fits ? rem_r : space);
          end
          // steps already taken before the final piece
          CMD_WRAPS: out_answer_value <= CountBits'(n_r);
          CMD_DIST: begin
            if (seg_r == sseg_r) begin
              if (n_r == '0)
                out_answer_value <= (off_r <= soff_r) ? LB'(soff_r - off_r)
                                   : total_r - LB'(off_r - soff_r);
              else out_answer_value <= dist_r + LB'(soff_r);
            end
          end
          default: out_answer_value <= '0;
        endcase
      end
    end
  end

endmodule

// ===== rtl/srpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// srpu_ctrl
// Sequencer: capture a request, step the walk, give results, commit.
// ----------------------------------------------------------------------------
module srpu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output srpu_pkg::srpu_cmd_t  ctl,
  input  srpu_pkg::srpu_sts_t  sts,
  output logic                 out_set,
  input  logic                 out_strobe_q,
  output logic                 out_strobe
);
  import srpu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    out_set    = 1'b0;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.refuse) begin
          out_set = 1'b1; strobe_nxt = 1'b1; state_nxt = ST_LAST;
        end else begin
          // piece commands give a result per step; queries only at the end
          if (sts.emit_step || sts.done) begin
            out_set = 1'b1; strobe_nxt = 1'b1;
          end
          if (sts.done) begin
            state_nxt = ST_LAST;
          end
          ctl.step = 1'b1;
        end
      end
      ST_LAST: begin
        if (!sts.refuse) ctl.commit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

  `include "segmented_ring_pointer_unit_defines.svh"

  `SRP_ASSERT_NEXT(a_load_walk, ctl.load, state_r == ST_WALK, "load must enter walk")
  `SRP_ASSERT_IMP(a_no_start_busy, ctl.load, !busy, "request taken while busy")
  `SRP_ASSERT_NEXT(a_strobe_follows, out_set, out_strobe_q, "result strobe missing")
  `SRP_ASSERT_IMP(a_commit_last, ctl.commit, state_r == ST_LAST, "commit outside last")

endmodule

// ===== rtl/segmented_ring_pointer_unit.sv =====
// ----------------------------------------------------------------------------
// segmented_ring_pointer_unit
// Ring pointer unit over up to MAX_SEGMENTS segments (six by default): advances, wrap counts, distances.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// in        start & !busy        in_cmd, in_count, in_first/second_*
// out       out_strobe (1 cycle) out_piece_*, out_answer_value, flags
// cfg       cfg_we               cfg_index, cfg_data
// A request takes a capture state, a walk step per segment walked and a commit
// state; the next request is accepted only once the unit is idle again.
// Each piece result appears the cycle after its walk step.
// Synchronous active-low reset; the receiver cannot stall.
module segmented_ring_pointer_unit #(
  parameter int MAX_SEGMENTS = srpu_pkg::MaxSegDefault,
  parameter int OFFSET_BITS  = srpu_pkg::OffBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [srpu_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [srpu_pkg::CfgDataBits-1:0]  cfg_data,
  input  logic [1:0]                        in_cmd,
  input  logic [srpu_pkg::CountBits-1:0]    in_count,
  input  logic [srpu_pkg::SegBits-1:0]      in_first_segment,
  input  logic [OFFSET_BITS-1:0]            in_first_offset,
  input  logic [srpu_pkg::SegBits-1:0]      in_second_segment,
  input  logic [OFFSET_BITS-1:0]            in_second_offset,
  output logic                              out_strobe,
  output logic [srpu_pkg::SegBits-1:0]      out_piece_segment,
  output logic [OFFSET_BITS-1:0]            out_piece_offset,
  output logic [srpu_pkg::CountBits-1:0]    out_piece_size,
  output logic [srpu_pkg::CountBits-1:0]    out_answer_value,
  output logic                              out_last_piece,
  output logic                              out_error_flag
);
  import srpu_pkg::*;

  srpu_cmd_t ctl;
  srpu_sts_t sts;
  logic      out_set;

  srpu_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .ctl, .sts, .out_set,
    .out_strobe_q(out_strobe), .out_strobe
  );

  srpu_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_cmd, .in_count, .in_first_segment, .in_first_offset,
    .in_second_segment, .in_second_offset,
    .ctl, .sts, .out_set,
    .out_piece_segment, .out_piece_offset, .out_piece_size,
    .out_answer_value, .out_last_piece, .out_error_flag
  );

endmodule
